// ===== src/hash_linear_probe_table_defines.svh =====
// Assertion macros shared by the hash table RTL.
`ifndef HASH_LINEAR_PROBE_TABLE_DEFINES_SVH
`define HASH_LINEAR_PROBE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define HLPT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hash table assertion failed");

// Condition must never be seen outside reset
`define HLPT_NEVER(lbl, clk, rst_n, cond) \
	`HLPT_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define HLPT_ASSERT(lbl, clk, rst_n, prop)
`define HLPT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/hlpt_pkg.sv =====
// Types, codes and field widths shared by the hash table modules.
`default_nettype none
package hlpt_pkg;

	// Field widths
	localparam int KEY_W      = 31;
	localparam int NAME_W     = 64;
	localparam int NAME_HI_W  = 32;
	localparam int QTY_W      = 31;
	localparam int PRICE_W    = 32;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int IDX_W      = 4;
	localparam int REC_W      = KEY_W + 2 * NAME_W + NAME_HI_W + QTY_W + PRICE_W;
	localparam int S_TDATA_W  = ((REC_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((REC_W + IDX_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - REC_W - IDX_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_KEY_ZERO  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

	// One stored record, key in the low bits as on the stream
	typedef struct packed {
		logic [PRICE_W-1:0]   price;
		logic [QTY_W-1:0]     quantity;
		logic [NAME_HI_W-1:0] name_high;
		logic [NAME_W-1:0]    name_mid;
		logic [NAME_W-1:0]    name_low;
		logic [KEY_W-1:0]     key;
	} record_t;

	// Controller to datapath
	typedef struct packed {
		logic                capture;
		logic                div_start;
		logic                probe_start;
		logic                rd;
		logic                wr_ins;
		logic                clr_start;
		logic                clr_wr;
		logic                cnt_clr;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_slot_sel;
		logic                res_found;
		logic                out_load;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             key_zero;
		logic             full;
		logic             div_done;
		logic             rvalid;
		logic             hit_empty;
		logic             hit_match;
		logic             probe_last;
		logic             clr_last;
		logic             out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/hlpt_mod.sv =====
// Key modulo table size by reciprocal multiplication and a back-subtract, both registered.
`default_nettype none
module hlpt_mod import hlpt_pkg::*; #(
	parameter int TABLE_SIZE = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [KEY_W-1:0]                  dividend,
	output logic                                   done,
	output logic [$clog2(TABLE_SIZE)-1:0]          rem
);

	localparam int SLOT_W = $clog2(TABLE_SIZE);
	// quotient = (key * RCP_M) >> RCP_SH, exact for every key of KEY_W bits
	localparam int RCP_SH = KEY_W + SLOT_W;
	localparam int RCP_W  = KEY_W + 1;
	localparam int PROD_W = 2 * KEY_W + 1;
	localparam int QUO_W  = PROD_W - RCP_SH;
	localparam longint unsigned RCP_FULL =
		((64'd1 << RCP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_FULL);

	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              valid_s1;
	logic [KEY_W-1:0]  back;
	logic              done_q;
	logic [SLOT_W-1:0] rem_q;

	// Multiply: quotient from the reciprocal (31 x 32 bit product)
	assign prod = PROD_W'(dividend) * PROD_W'(RCP_M);

	// Back-subtract: remainder = key - quotient * table size
	assign back = KEY_W'(quo_s1) * KEY_W'(TABLE_SIZE);

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_q   <= valid_s1;
		end
	end

	// Quotient and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_s1 <= prod[PROD_W-1:RCP_SH];
			key_s1 <= dividend;
		end
		if (valid_s1) begin
			rem_q <= SLOT_W'(key_s1 - back);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== src/hlpt_dp.sv =====
// Datapath: request registers, slot memory, probe pointer, result and output registers.
`default_nettype none
`include "hash_linear_probe_table_defines.svh"
module hlpt_dp import hlpt_pkg::*; #(
	parameter int TABLE_SIZE = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_stat_t                   stat,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic [STATUS_W-1:0]        m_tuser
);

	localparam int SLOT_W = $clog2(TABLE_SIZE);
	localparam int CNT_W  = $clog2(TABLE_SIZE);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

	// Captured request
	logic [CMD_W-1:0]    cmd_q;
	record_t             rec_in_q;

	// Probe / sweep pointer and memory read stage
	logic [SLOT_W-1:0]   ptr_q;
	logic [SLOT_W-1:0]   ptr_inc;
	logic [SLOT_W-1:0]   hash_rem;
	logic                div_done;
	logic [SLOT_W-1:0]   eval_cnt_q;
	logic [SLOT_W-1:0]   raddr_s1;
	logic                rvalid_s1;
	record_t             rdata_s1;
	record_t             mem [TABLE_SIZE];

	// Occupancy and result
	logic [CNT_W-1:0]    count_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_found_q;

	// Output register
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= s_tuser;
			rec_in_q <= record_t'(s_tdata[REC_W-1:0]);
		end
	end

	// Home slot
	hlpt_mod #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rec_in_q.key),
		.done     (div_done),
		.rem      (hash_rem)
	);

	// Next slot with wraparound
	assign ptr_inc = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;

	// Pointer, probe counter, read valid flag and occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			eval_cnt_q <= '0;
			rvalid_s1  <= 1'b0;
			count_q    <= '0;
		end else begin
			rvalid_s1 <= cmd.rd;
			if (cmd.probe_start) begin
				ptr_q <= hash_rem;
			end else if (cmd.clr_start) begin
				ptr_q <= '0;
			end else if (cmd.rd || cmd.clr_wr) begin
				ptr_q <= ptr_inc;
			end
			if (cmd.probe_start) begin
				eval_cnt_q <= '0;
			end else if (rvalid_s1) begin
				eval_cnt_q <= eval_cnt_q + 1'b1;
			end
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.wr_ins) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_ins) begin
			mem[raddr_s1] <= rec_in_q;
		end else if (cmd.clr_wr) begin
			mem[ptr_q] <= '0;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[ptr_q];
			raddr_s1 <= ptr_q;
		end
	end

	// Result held until the output register frees
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_slot_q   <= cmd.res_slot_sel ? raddr_s1 : '0;
			res_found_q  <= cmd.res_found;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, IDX_W'(res_slot_q),
				res_found_q ? rdata_s1 : record_t'('0)};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Status back to the controller
	always_comb begin
		stat            = '0;
		stat.cmd        = cmd_q;
		stat.key_zero   = (rec_in_q.key == '0);
		stat.full       = (count_q >= CNT_W'(TABLE_SIZE - 1));
		stat.div_done   = div_done;
		stat.rvalid     = rvalid_s1;
		stat.hit_empty  = (rdata_s1.key == '0);
		stat.hit_match  = (rdata_s1.key == rec_in_q.key);
		stat.probe_last = (eval_cnt_q == LAST_SLOT);
		stat.clr_last   = (ptr_q == LAST_SLOT);
		stat.out_free   = !m_tvalid_q || m_tready;
	end

	`HLPT_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(TABLE_SIZE - 1))
	`HLPT_ASSERT(a_ins_not_full, clk, arst_n, cmd.wr_ins |-> count_q < CNT_W'(TABLE_SIZE - 1))
	`HLPT_ASSERT(a_found_is_match, clk, arst_n, (cmd.res_load && cmd.res_found) |-> (rvalid_s1 && rdata_s1.key == rec_in_q.key && rec_in_q.key != '0))

endmodule
`default_nettype wire

// ===== src/hlpt_ctrl.sv =====
// Controller: sequences clearing sweep, hashing, probing and result hand-off.
`default_nettype none
`include "hash_linear_probe_table_defines.svh"
module hlpt_ctrl import hlpt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	localparam logic [2:0] S_INIT     = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_HASH     = 3'd3;
	localparam logic [2:0] S_PROBE    = 3'd4;
	localparam logic [2:0] S_CLR      = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_INIT, S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					cmd.cnt_clr = 1'b1;
					if (state_q == S_INIT) begin
						state_d = S_IDLE;
					end else begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_CLEARED;
						state_d        = S_DONE;
					end
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.key_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_KEY_ZERO;
							state_d        = S_DONE;
						end else if (stat.full) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_DONE;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_HASH;
						end
					end
					CMD_SEARCH: begin
						if (stat.key_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
							state_d        = S_DONE;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_HASH;
						end
					end
					CMD_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_DONE;
					end
				endcase
			end
			S_HASH: begin
				if (stat.div_done) begin
					cmd.probe_start = 1'b1;
					state_d         = S_PROBE;
				end
			end
			S_PROBE: begin
				// one read per cycle; each slot is checked the cycle after
				cmd.rd = 1'b1;
				if (stat.rvalid) begin
					if (stat.cmd == CMD_INSERT) begin
						if (stat.hit_empty) begin
							cmd.rd           = 1'b0;
							cmd.wr_ins       = 1'b1;
							cmd.res_load     = 1'b1;
							cmd.res_status   = ST_INSERTED;
							cmd.res_slot_sel = 1'b1;
							state_d          = S_DONE;
						end else if (stat.probe_last) begin
							cmd.rd         = 1'b0;
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_DONE;
						end
					end else begin
						if (stat.hit_match) begin
							cmd.rd           = 1'b0;
							cmd.res_load     = 1'b1;
							cmd.res_status   = ST_FOUND;
							cmd.res_slot_sel = 1'b1;
							cmd.res_found    = 1'b1;
							state_d          = S_DONE;
						end else if (stat.hit_empty || stat.probe_last) begin
							cmd.rd         = 1'b0;
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
							state_d        = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	`HLPT_NEVER(a_no_rd_on_write, clk, arst_n, cmd.wr_ins && cmd.rd)
	`HLPT_ASSERT(a_out_load_free, clk, arst_n, cmd.out_load |-> stat.out_free)
	`HLPT_ASSERT(a_hash_to_probe, clk, arst_n, (state_q == S_HASH) |=> (state_q == S_HASH || state_q == S_PROBE))

endmodule
`default_nettype wire

// ===== src/hash_linear_probe_table.sv =====
// Top level: open-addressing stock table with linear probing.
//
// Requests enter on the s_ group: s_tuser carries the command (insert, search,
// clear), s_tdata the key and record. One result per request leaves on the m_
// group: m_tuser the status, m_tdata the found record and slot number.
// The home slot is key mod TABLE_SIZE, worked out by a reciprocal multiply and
// a back-subtract. Probing then reads one slot per cycle from the slot memory
// and checks each slot in the next cycle; probing visits at most TABLE_SIZE
// slots. A zero key, an insert into a full table or an unknown command is
// answered straight from dispatch, without hashing or probing. Clear sweeps
// the memory, one slot a cycle. One request is worked on at a time; the next
// is taken in the cycle after the result has moved into the output register.
// After reset the block sweeps every slot empty with s_tready low. A stalled
// m_tready holds the result in the output register; the block accepts one
// more request but holds its result until the register frees.
`default_nettype none
module hash_linear_probe_table import hlpt_pkg::*; #(
	parameter int TABLE_SIZE = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// key, name_low, name_mid, name_high, quantity, price_bits
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// command
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// found_key, found_name_low, found_name_mid, found_name_high,
	// found_quantity, found_price_bits, slot_index
	output logic [M_TDATA_W-1:0]       m_tdata,
	// status
	output logic [STATUS_W-1:0]        m_tuser
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	hlpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hlpt_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
